>>> sv/sectioned_xor_keystream_cipher_assert.svh
// Assertion macros used by the cipher's checker file.
`ifndef SECTIONED_XOR_KEYSTREAM_CIPHER_ASSERT_SVH
`define SECTIONED_XOR_KEYSTREAM_CIPHER_ASSERT_SVH

// Checked on every clock edge outside reset.
`define SXKC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// Checked on every clock edge, reset included.
`define SXKC_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) \
      else $error(msg);

`endif

>>> sv/sxkc_pkg.sv
// Package: constants, types and generator jump functions of the XOR keystream cipher.
package sxkc_pkg;

   localparam int unsigned SECTION_COUNT             = 256;
   localparam int unsigned KEY_SECTION_BYTES_DEFAULT = 2048;
   localparam int unsigned WORD_BYTES                = 8;
   localparam int unsigned DATA_W                    = 64;
   localparam int unsigned SECTION_W                 = 8;
   localparam int unsigned BYTES_LEFT_W              = 12;
   // decrypt of a package's first unit handles a word down to this many bytes
   localparam int unsigned DECRYPT_FIRST_MIN_BYTES   = 4;

   localparam logic [31:0] LCG_SEED = 32'hDEADBEEF;
   localparam logic [31:0] LCG_MUL  = 32'd214013;
   localparam logic [31:0] LCG_INC  = 32'd2531011;

   typedef enum logic [0:0] {
      KIND_ENCRYPT = 1'b0,
      KIND_DECRYPT = 1'b1
   } kind_type;

   // word held between the memory read and the output register
   typedef struct packed {
      logic                 handle;
      logic                 header;
      logic [SECTION_W-1:0] section;
      logic [DATA_W-1:0]    data;
   } stage_type;

   // multiplier of the generator advanced by the given number of steps
   function automatic logic [31:0] lcg_jump_mul(input int unsigned steps);
      logic [31:0] m;
      m = 32'd1;
      for (int unsigned i = 0; i < steps; i++) begin
         m = m * LCG_MUL;
      end
      return m;
   endfunction

   // increment of the generator advanced by the given number of steps
   function automatic logic [31:0] lcg_jump_inc(input int unsigned steps);
      logic [31:0] c;
      c = 32'd0;
      for (int unsigned i = 0; i < steps; i++) begin
         c = c * LCG_MUL + LCG_INC;
      end
      return c;
   endfunction

endpackage

>>> sv/sxkc_if.sv
// Valid/ready channel interfaces for the cipher's request and response sides.
interface sxkc_req_if import sxkc_pkg::*; ();
   logic                    valid;
   logic                    ready;
   kind_type                kind;
   logic [DATA_W-1:0]       data_in;
   logic [SECTION_W-1:0]    section;
   logic                    first_of_package;
   logic                    unit_start;
   logic [BYTES_LEFT_W-1:0] bytes_left;

   modport source (output valid, kind, data_in, section, first_of_package,
                   unit_start, bytes_left, input ready);
   modport sink   (input valid, kind, data_in, section, first_of_package,
                   unit_start, bytes_left, output ready);
endinterface

interface sxkc_rsp_if import sxkc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] data_out;

   modport source (output valid, data_out, input ready);
   modport sink   (input valid, data_out, output ready);
endinterface

>>> sv/sxkc_ram.sv
// Generic single-port RAM with registered read data.
module sxkc_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/sectioned_xor_keystream_cipher.sv
// A transferred word passes through stage 1 and then the output register before it is shown.
// Throughput: one word per cycle unless the output stalls; one memory read per word.
// Reset (synchronous): clears the pipeline and restarts the keystream fill, which writes
// one 64-bit memory word per cycle, SECTION_COUNT * KEY_SECTION_BYTES / 8 words in all
// (65536 at the default); no request is taken until it ends.
// KEY_SECTION_BYTES must be a multiple of 8; the block itself does not enforce it.
module sectioned_xor_keystream_cipher import sxkc_pkg::*; #(
   parameter int unsigned KEY_SECTION_BYTES = KEY_SECTION_BYTES_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sxkc_req_if.sink  req,
   sxkc_rsp_if.source rsp
);

   localparam int unsigned SECTION_WORDS = KEY_SECTION_BYTES / WORD_BYTES;
   localparam int unsigned STORE_WORDS   = SECTION_COUNT * SECTION_WORDS;
   localparam int unsigned ADDR_W        = $clog2(STORE_WORDS);
   localparam int unsigned POS_W         = $clog2(SECTION_WORDS + 1);

   // ------------------------------------------------------------------
   // Keystream fill. Eight generator steps per word, done as eight
   // independent jump-ahead products from the current generator value.
   // ------------------------------------------------------------------
   logic [31:0]       gen_ff, gen_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic              fill_busy_ff, fill_busy_in;
   logic [DATA_W-1:0] fill_word;
   logic [31:0]       gen_step [WORD_BYTES];

   for (genvar k = 0; k < WORD_BYTES; k++) begin : g_jump
      localparam logic [31:0] JMUL = lcg_jump_mul(k + 1);
      localparam logic [31:0] JINC = lcg_jump_inc(k + 1);
      assign gen_step[k] = gen_ff * JMUL + JINC;
      // byte k of the word is bits 23:16 of the generator after step k+1
      assign fill_word[8*k +: 8] = gen_step[k][23:16];
   end

   always_comb begin
      gen_in       = gen_ff;
      fill_addr_in = fill_addr_ff;
      fill_busy_in = fill_busy_ff;
      if (fill_busy_ff) begin
         gen_in = gen_step[WORD_BYTES-1];
         if (fill_addr_ff == ADDR_W'(STORE_WORDS - 1)) begin
            fill_busy_in = 1'b0;
         end else begin
            fill_addr_in = fill_addr_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side: position tracking, handle decision, memory read.
   // ------------------------------------------------------------------
   logic              s1_valid_ff, s1_valid_in;
   stage_type         s1_ff, s1_in;
   logic              out_valid_ff, out_valid_in;
   logic [DATA_W-1:0] out_data_ff, out_data_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   logic              accept;
   logic              advance;
   logic [POS_W-1:0]  pos_cur;
   logic              in_section;
   logic              len_ok;
   logic              handle;
   logic [ADDR_W-1:0] rd_addr;

   logic              ram_en;
   logic [ADDR_W-1:0] ram_addr;
   logic [DATA_W-1:0] ram_rdata;

   // stage 1 moves on when the output register is empty or drains now
   assign advance   = s1_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !reset && !fill_busy_ff && (!s1_valid_ff || advance);
   assign accept    = req.valid && req.ready;

   // a unit start restarts the position at word 0
   assign pos_cur    = req.unit_start ? '0 : pos_ff;
   assign in_section = pos_cur < POS_W'(SECTION_WORDS);

   always_comb begin
      case (req.kind)
         KIND_ENCRYPT: len_ok = req.bytes_left >= BYTES_LEFT_W'(WORD_BYTES);
         KIND_DECRYPT: begin
            // first unit of a package: the header bytes count as payload
            if (req.first_of_package) begin
               len_ok = req.bytes_left >= BYTES_LEFT_W'(DECRYPT_FIRST_MIN_BYTES);
            end else begin
               len_ok = req.bytes_left >= BYTES_LEFT_W'(WORD_BYTES);
            end
         end
         default: len_ok = 1'b0;
      endcase
   end

   assign handle  = len_ok && in_section;
   assign rd_addr = ADDR_W'(req.section) * ADDR_W'(SECTION_WORDS) + ADDR_W'(pos_cur);

   always_comb begin
      pos_in = pos_ff;
      if (accept) begin
         pos_in = in_section ? pos_cur + 1'b1 : pos_cur;   // saturates at section end
      end
   end

   always_comb begin
      s1_in.handle  = handle;
      s1_in.header  = (req.kind == KIND_ENCRYPT) && req.unit_start && req.first_of_package;
      s1_in.section = req.section;
      s1_in.data    = req.data_in;
   end

   assign s1_valid_in = accept || (s1_valid_ff && !advance);

   // memory port: fill writes first, afterwards reads only for handled words
   assign ram_en   = fill_busy_ff || (accept && handle);
   assign ram_addr = fill_busy_ff ? fill_addr_ff : rd_addr;

   sxkc_ram #(
      .WIDTH(DATA_W),
      .DEPTH(STORE_WORDS)
   ) u_keystream (
      .clock(clock),
      .en   (ram_en),
      .we   (fill_busy_ff),
      .addr (ram_addr),
      .wdata(fill_word),
      .rdata(ram_rdata)
   );

   // ------------------------------------------------------------------
   // Stage 1: XOR with the key word, header byte, into the output register.
   // Read data holds while stage 1 stalls since no new read is issued.
   // ------------------------------------------------------------------
   logic [DATA_W-1:0] key_word;
   logic [DATA_W-1:0] result;

   always_comb begin
      key_word = s1_ff.handle ? ram_rdata : '0;
      result   = s1_ff.data ^ key_word;
      if (s1_ff.header) begin
         // encrypt header: bytes 0..2 plain, section number in byte 3
         result[31:0] = {s1_ff.section, s1_ff.data[23:0]};
      end
   end

   assign out_valid_in = advance || (out_valid_ff && !rsp.ready);
   assign out_data_in  = advance ? result : out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff       <= LCG_SEED;
         fill_addr_ff <= '0;
         fill_busy_ff <= 1'b1;
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         gen_ff       <= gen_in;
         fill_addr_ff <= fill_addr_in;
         fill_busy_ff <= fill_busy_in;
         pos_ff       <= pos_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff <= s1_in;
      end
      out_data_ff <= out_data_in;
   end

   assign rsp.valid    = out_valid_ff;
   assign rsp.data_out = out_data_ff;

endmodule

>>> sv/sxkc_checker.sv
// Port-level checks of the cipher, bound to its top level.
`include "sectioned_xor_keystream_cipher_assert.svh"

module sxkc_checker import sxkc_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_data_out
);

   // reset restarts the fill, so no request is taken right after it
   `SXKC_ASSERT_ALWAYS(a_reset_blocks_req, reset |=> !req_ready, "request taken right after reset")
   `SXKC_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "response valid right after reset")
   // a response only appears after a request transfer, through stage 1 and the output register
   `SXKC_ASSERT(a_rsp_follows_req, $rose(rsp_valid) |-> $past(req_valid && req_ready, 2), "response without request")
   `SXKC_ASSERT(a_rsp_holds, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data_out), "stalled response changed")

endmodule

bind sectioned_xor_keystream_cipher sxkc_checker u_sxkc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_data_out(rsp.data_out)
);

>>> test/tb.sv
`timescale 1ns / 100ps
// Testbench for the XOR keystream cipher: directed and random words checked against a local model.
module tb import sxkc_pkg::*;;

   // Geometry of the keystream store at the block's default size
   localparam int unsigned SECTION_BYTES = KEY_SECTION_BYTES_DEFAULT;
   localparam int unsigned SECTION_WORDS = SECTION_BYTES / WORD_BYTES;
   localparam int unsigned STORE_BYTES   = SECTION_COUNT * SECTION_BYTES;
   localparam int unsigned MAX_UNIT_BYTES = SECTION_BYTES;

   localparam int unsigned MAX_WAIT     = 10;   // longest gap / stall per transfer
   localparam int unsigned CALM_PERIOD  = 64;   // transfers between idle-mode redraws
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned DRAIN_CYCLES = 8;    // wait after the last result is taken
   localparam int unsigned RANDOM_WORDS = 1400;
   localparam int unsigned EXTRA_WORDS  = 12;   // words sent past a full section

   localparam logic [DATA_W-1:0] ALL_ONES = {DATA_W{1'b1}};

   logic clock;
   logic reset;

   sxkc_req_if req_if ();
   sxkc_rsp_if rsp_if ();

   sectioned_xor_keystream_cipher i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   // Model state: keystream bytes, word position within the current unit
   logic [7:0]        key_bytes [STORE_BYTES];
   int unsigned       unit_position;
   logic [31:0]       lcg_state;

   // Expected data_out values, oldest first
   logic [DATA_W-1:0] pending_outputs [$];

   int unsigned       sent_words;
   int unsigned       received_words;
   int unsigned       error_count;

   // Idle control: a calm phase means no gaps on that side
   logic              send_calm;
   logic              recv_calm;
   int unsigned       recv_stall;
   logic [DATA_W-1:0] wanted_output;

   //---------------------------------------------------------------------------
   // Clock and timeout
   //---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Timeout for the whole run, keystream fill included.
   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   //---------------------------------------------------------------------------
   // Cipher model: expected data_out for one word; advances the unit position.
   //---------------------------------------------------------------------------
   function automatic logic [DATA_W-1:0] cipher_word(
      input kind_type                kind,
      input logic [DATA_W-1:0]       data,
      input logic [SECTION_W-1:0]    section,
      input logic                    first_pkg,
      input logic                    unit_start,
      input logic [BYTES_LEFT_W-1:0] bytes_left
   );
      int unsigned       pos;
      int unsigned       base;
      logic              apply;
      logic [DATA_W-1:0] key;
      logic [DATA_W-1:0] result;

      if (unit_start) begin
         unit_position = 0;
      end
      pos = unit_position;

      // Decrypt of a package's first unit still covers a 4-byte tail word
      if (kind == KIND_DECRYPT && first_pkg) begin
         apply = (bytes_left >= DECRYPT_FIRST_MIN_BYTES);
      end else begin
         apply = (bytes_left >= WORD_BYTES);
      end
      // Past the end of the section there is no key left
      if (pos >= SECTION_WORDS) begin
         apply = 1'b0;
      end

      result = data;
      if (apply) begin
         base = section * SECTION_BYTES + pos * WORD_BYTES;
         for (int b = 0; b < WORD_BYTES; b++) begin
            key[8*b +: 8] = key_bytes[base + b];
         end
         result = data ^ key;
      end

      // Encrypt header: bytes 0..2 stay plain, section number goes in byte 3
      if (kind == KIND_ENCRYPT && unit_start && first_pkg) begin
         result[31:0] = {section, data[23:0]};
      end

      if (unit_position < SECTION_WORDS) begin
         unit_position++;
      end
      return result;
   endfunction

   //---------------------------------------------------------------------------
   // Request side: one word per call, with a random gap ahead of it.
   // Returns at the edge of the transfer, with the expectation queued.
   //---------------------------------------------------------------------------
   task automatic send_word(
      input kind_type                kind,
      input logic [DATA_W-1:0]       data,
      input logic [SECTION_W-1:0]    section,
      input logic                    first_pkg,
      input logic                    unit_start,
      input logic [BYTES_LEFT_W-1:0] bytes_left
   );
      int unsigned gap;

      if (sent_words % CALM_PERIOD == 0) begin
         send_calm = ($urandom_range(0, 2) == 0);
      end
      gap = send_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end

      req_if.valid            <= 1'b1;
      req_if.kind             <= kind;
      req_if.data_in          <= data;
      req_if.section          <= section;
      req_if.first_of_package <= first_pkg;
      req_if.unit_start       <= unit_start;
      req_if.bytes_left       <= bytes_left;

      // ready stays low through the keystream fill; just wait for the transfer
      do @(posedge clock); while (req_if.ready !== 1'b1);

      pending_outputs.push_back(
         cipher_word(kind, data, section, first_pkg, unit_start, bytes_left));
      sent_words++;
   endtask

   //---------------------------------------------------------------------------
   // Response side: random stalls after each transfer, result checking.
   //---------------------------------------------------------------------------
   initial begin
      rsp_if.ready = 1'b0;
      recv_stall   = 0;
      recv_calm    = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_outputs.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("%0t: unexpected result data_out=%h", $realtime, rsp_if.data_out);
               end
            end else begin
               wanted_output = pending_outputs.pop_front();
               if (rsp_if.data_out !== wanted_output) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("%0t: data_out mismatch on result %0d: expected %h, got %h",
                              $realtime, received_words, wanted_output, rsp_if.data_out);
                  end
               end
            end
            received_words++;

            if (received_words % CALM_PERIOD == 0) begin
               recv_calm = ($urandom_range(0, 2) == 0);
            end
            recv_stall = recv_calm ? 0 : $urandom_range(0, MAX_WAIT);
            if (recv_stall > 0) begin
               rsp_if.ready <= 1'b0;
            end
         end else if (rsp_if.ready !== 1'b1) begin
            if (recv_stall > 0) begin
               recv_stall--;
            end
            if (recv_stall == 0) begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   //---------------------------------------------------------------------------
   // Tests
   //---------------------------------------------------------------------------

   // Field extremes, both kinds, header word, and the tail-word thresholds
   task automatic test_directed_edges();
      // encrypt header with full XOR, then header on a short tail (no XOR)
      send_word(KIND_ENCRYPT, '0,       8'h00, 1'b1, 1'b1, 12'd2048);
      send_word(KIND_ENCRYPT, ALL_ONES, 8'hFF, 1'b1, 1'b1, 12'd7);
      send_word(KIND_ENCRYPT, ALL_ONES, 8'hAA, 1'b1, 1'b1, 12'd0);
      // encrypt threshold at exactly one word
      send_word(KIND_ENCRYPT, ALL_ONES, 8'hFF, 1'b0, 1'b1, 12'd8);
      send_word(KIND_ENCRYPT, ALL_ONES, 8'hFF, 1'b0, 1'b0, 12'd7);
      send_word(KIND_ENCRYPT, '0,       8'h01, 1'b0, 1'b0, 12'd0);
      // first-of-package flag without unit start: XOR but no header byte
      send_word(KIND_ENCRYPT, 64'h0123_4567_89AB_CDEF, 8'h80, 1'b1, 1'b0, 12'd8);
      send_word(KIND_ENCRYPT, 64'hFEDC_BA98_7654_3210, 8'h80, 1'b0, 1'b1, 12'd2048);
      // decrypt of a first unit covers a 4-byte tail, not a 3-byte one
      send_word(KIND_DECRYPT, ALL_ONES, 8'h7F, 1'b1, 1'b1, 12'd4);
      send_word(KIND_DECRYPT, ALL_ONES, 8'h7F, 1'b1, 1'b0, 12'd3);
      send_word(KIND_DECRYPT, '0,       8'h7F, 1'b1, 1'b0, 12'd7);
      // ordinary decrypt needs the full word
      send_word(KIND_DECRYPT, ALL_ONES, 8'h10, 1'b0, 1'b1, 12'd4);
      send_word(KIND_DECRYPT, ALL_ONES, 8'h10, 1'b0, 1'b0, 12'd8);
      send_word(KIND_DECRYPT, ALL_ONES, 8'h10, 1'b0, 1'b0, 12'd7);
      send_word(KIND_DECRYPT, '0,       8'h10, 1'b0, 1'b0, 12'd0);
      // decrypt never touches the header byte
      send_word(KIND_DECRYPT, '0,       8'h00, 1'b1, 1'b1, 12'd2048);
      send_word(KIND_DECRYPT, ALL_ONES, 8'hFF, 1'b0, 1'b1, 12'd2048);
      send_word(KIND_ENCRYPT, ALL_ONES, 8'hFF, 1'b0, 1'b0, 12'd2040);
   endtask

   // A unit that spans the whole section, then words beyond its end
   task automatic test_section_end();
      kind_type             kind;
      logic [SECTION_W-1:0] section;
      logic                 first_pkg;

      for (int pass_idx = 0; pass_idx < 2; pass_idx++) begin
         kind      = pass_idx == 0 ? KIND_ENCRYPT : KIND_DECRYPT;
         section   = SECTION_W'($urandom_range(0, SECTION_COUNT - 1));
         first_pkg = 1'($urandom_range(0, 1));
         for (int i = 0; i < SECTION_WORDS; i++) begin
            send_word(kind, {$urandom, $urandom}, section, first_pkg, i == 0,
                      BYTES_LEFT_W'(MAX_UNIT_BYTES - WORD_BYTES * i));
         end
         // position is saturated here: every word must come back unchanged
         for (int i = 0; i < EXTRA_WORDS; i++) begin
            send_word(kind_type'($urandom_range(0, 1)), {$urandom, $urandom},
                      SECTION_W'($urandom_range(0, SECTION_COUNT - 1)),
                      1'($urandom_range(0, 1)), 1'b0,
                      BYTES_LEFT_W'($urandom_range(0, MAX_UNIT_BYTES)));
         end
      end
   endtask

   // Mostly well-formed units of random size and content, some cut short,
   // mixed with stray words carrying arbitrary fields
   task automatic test_random_units();
      kind_type             kind;
      logic [SECTION_W-1:0] section;
      logic                 first_pkg;
      int unsigned          unit_bytes;
      int unsigned          words;
      int unsigned          target;

      target = sent_words + RANDOM_WORDS;
      while (sent_words < target) begin
         if ($urandom_range(0, 99) < 15) begin
            send_word(kind_type'($urandom_range(0, 1)), {$urandom, $urandom},
                      SECTION_W'($urandom_range(0, SECTION_COUNT - 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      BYTES_LEFT_W'($urandom_range(0, MAX_UNIT_BYTES)));
         end else begin
            kind      = kind_type'($urandom_range(0, 1));
            section   = SECTION_W'($urandom_range(0, SECTION_COUNT - 1));
            first_pkg = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 19))
               0: begin
                  unit_bytes = $urandom_range(601, MAX_UNIT_BYTES);
               end
               1, 2, 3, 4, 5: begin
                  unit_bytes = $urandom_range(161, 600);
               end
               default: begin
                  unit_bytes = $urandom_range(1, 160);
               end
            endcase
            words = (unit_bytes + WORD_BYTES - 1) / WORD_BYTES;
            // broken unit: the next unit starts before this one ends
            if ($urandom_range(0, 9) == 0) begin
               words = $urandom_range(1, words);
            end
            for (int i = 0; i < words; i++) begin
               send_word(kind, {$urandom, $urandom}, section, first_pkg, i == 0,
                         BYTES_LEFT_W'(unit_bytes - WORD_BYTES * i));
            end
         end
      end
   endtask

   //---------------------------------------------------------------------------
   // Main sequence
   //---------------------------------------------------------------------------
   initial begin
      // Keystream as the block fills it: one generator step per byte
      lcg_state = LCG_SEED;
      for (int i = 0; i < STORE_BYTES; i++) begin
         lcg_state    = lcg_state * LCG_MUL + LCG_INC;
         key_bytes[i] = lcg_state[23:16];
      end
      unit_position  = 0;
      sent_words     = 0;
      received_words = 0;
      error_count    = 0;
      send_calm      = 1'b0;

      reset                   = 1'b1;
      req_if.valid            = 1'b0;
      req_if.kind             = KIND_ENCRYPT;
      req_if.data_in          = '0;
      req_if.section          = '0;
      req_if.first_of_package = 1'b0;
      req_if.unit_start       = 1'b0;
      req_if.bytes_left       = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_edges();
      test_section_end();
      test_random_units();
      req_if.valid <= 1'b0;

      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_outputs.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
